// ===== hw/rtl/sde_pkg.sv =====
package sde_pkg;

  localparam int LEAF_SIZE_DEF  = 256;
  localparam int VALUE_BITS_DEF = 64;

  localparam int FUNC_W   = 2;
  localparam int DATA_W   = 64;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 9;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DICT   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CODE   = 2'd3;

  typedef struct packed {
    logic               insert;
    logic [INDEX_W-1:0] rank;
  } chain_ctrl_t;

endpackage

// ===== hw/rtl/sde_if.sv =====
interface sde_in_if;
  import sde_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] element_value;
  logic [INDEX_W-1:0]       read_index;

  modport source (output valid, func, element_value, read_index, input ready);
  modport sink   (input valid, func, element_value, read_index, output ready);
endinterface

interface sde_out_if;
  import sde_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [COUNT_W-1:0]       element_count;
  logic [COUNT_W-1:0]       distinct_count;
  logic                     error_flag;

  modport source (output valid, result_value, element_count, distinct_count, error_flag,
                  input ready);
  modport sink   (input valid, result_value, element_count, distinct_count, error_flag,
                  output ready);
endinterface

// ===== hw/rtl/sorted_dictionary_encoder.sv =====
// Channel  Dir  Payload                                              Handshake
// in_item  in   func, element_value, read_index                      valid/ready
// out_item out  result_value, element_count, distinct_count, error   valid/ready
//
// Clear, append and dictionary read write the result register directly; an
// append inserts through the cell row in the same cycle. A position code read
// first reads the element store, then matches across the row.
// Reset clears the counts, state and output valid only; store contents are never read before written.
// Input stalls while the result register is full and not being taken, and
// for the match cycle of a position code read.
module sorted_dictionary_encoder
  import sde_pkg::*;
#(
  parameter int LEAF_SIZE  = LEAF_SIZE_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sde_in_if.sink       in_item,
  sde_out_if.source    out_item
);

  localparam int AW = $clog2(LEAF_SIZE);
  localparam int CW = $clog2(LEAF_SIZE + 1);
  localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
  localparam int KW = (CW > INDEX_W) ? CW : INDEX_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RANK = 1'b1;

  logic                         state_r, state_nxt;
  logic [CW-1:0]                ecnt_r, ecnt_nxt;
  logic [CW-1:0]                dcnt_r, dcnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0]     res_r, res_nxt;
  logic [COUNT_W-1:0]           oecnt_r, oecnt_nxt;
  logic [COUNT_W-1:0]           odcnt_r, odcnt_nxt;
  logic                         err_r, err_nxt;

  logic [VALUE_BITS-1:0]        mem [LEAF_SIZE];
  logic signed [VALUE_BITS-1:0] mem_q;
  logic                         wr_en;

  logic                         acc;
  logic                         load;
  logic                         full;
  logic [IW-1:0]                idx_w;
  logic [AW-1:0]                rd_addr;
  logic signed [VALUE_BITS-1:0] new_val;
  logic signed [VALUE_BITS-1:0] key;
  chain_ctrl_t                  ctrl;
  logic                         dup;
  logic [CW-1:0]                code;
  logic [VALUE_BITS-1:0]        rd_val;

  assign in_item.ready = (state_r == ST_IDLE) && (!out_valid_r || out_item.ready);
  assign acc           = in_item.valid && in_item.ready;
  assign full          = ecnt_r == CW'(LEAF_SIZE);
  assign idx_w         = IW'(in_item.read_index);
  assign rd_addr       = idx_w[AW-1:0];
  assign new_val       = in_item.element_value[VALUE_BITS-1:0];
  assign key           = (state_r == ST_RANK) ? mem_q : new_val;

  sde_chain #(.LEAF_SIZE(LEAF_SIZE), .VB(VALUE_BITS), .CW(CW)) u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .key   (key),
    .dcnt  (dcnt_r),
    .dup   (dup),
    .code  (code),
    .rd_val(rd_val)
  );

  always_comb begin
    state_nxt   = state_r;
    ecnt_nxt    = ecnt_r;
    dcnt_nxt    = dcnt_r;
    load        = 1'b0;
    res_nxt     = res_r;
    err_nxt     = err_r;
    wr_en       = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.rank   = in_item.read_index;
    if (state_r == ST_RANK) begin
      load      = 1'b1;
      res_nxt   = DATA_W'(code);
      err_nxt   = 1'b0;
      state_nxt = ST_IDLE;
    end else if (acc) begin
      load    = 1'b1;
      res_nxt = '0;
      err_nxt = 1'b0;
      case (in_item.func)
        FUNC_CLEAR: begin
          ecnt_nxt = '0;
          dcnt_nxt = '0;
        end
        FUNC_APPEND: begin
          if (full) begin
            err_nxt = 1'b1;
          end else begin
            wr_en    = 1'b1;
            res_nxt  = DATA_W'(ecnt_r);
            ecnt_nxt = ecnt_r + CW'(1);
            if (!dup) begin
              ctrl.insert = 1'b1;
              dcnt_nxt    = dcnt_r + CW'(1);
            end
          end
        end
        FUNC_DICT: begin
          if (KW'(in_item.read_index) < KW'(dcnt_r)) begin
            res_nxt = DATA_W'(signed'(rd_val));
          end else begin
            err_nxt = 1'b1;
          end
        end
        FUNC_CODE: begin
          if (KW'(in_item.read_index) < KW'(ecnt_r)) begin
            load      = 1'b0;
            state_nxt = ST_RANK;
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end
    oecnt_nxt     = load ? COUNT_W'(ecnt_nxt) : oecnt_r;
    odcnt_nxt     = load ? COUNT_W'(dcnt_nxt) : odcnt_r;
    out_valid_nxt = load || (out_valid_r && !out_item.ready);
    if (!load) begin
      res_nxt = res_r;
      err_nxt = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ecnt_r      <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ecnt_r      <= ecnt_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    err_r   <= err_nxt;
    oecnt_r <= oecnt_nxt;
    odcnt_r <= odcnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ecnt_r[AW-1:0]] <= new_val;
    end
    if (acc) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign out_item.valid          = out_valid_r;
  assign out_item.result_value   = res_r;
  assign out_item.element_count  = oecnt_r;
  assign out_item.distinct_count = odcnt_r;
  assign out_item.error_flag     = err_r;

endmodule

// ===== hw/rtl/sde_cell.sv =====
module sde_cell
  import sde_pkg::*;
#(
  parameter int VB  = VALUE_BITS_DEF,
  parameter int CW  = COUNT_W,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  chain_ctrl_t          ctrl,
  input  logic signed [VB-1:0] key,
  input  logic [CW-1:0]        dcnt,
  input  logic signed [VB-1:0] left_val,
  input  logic                 left_lt,
  output logic signed [VB-1:0] val,
  output logic                 lt,
  output logic                 eq,
  output logic [VB-1:0]        sel_val
);

  logic signed [VB-1:0] val_r;
  logic signed [VB-1:0] val_nxt;
  logic                 occ;

  assign occ = int'(dcnt) > IDX;
  assign lt  = occ && (val_r < key);
  assign eq  = occ && (val_r == key);
  assign val = val_r;

  assign sel_val = (occ && int'(ctrl.rank) == IDX) ? val_r : '0;

  // sorted insert: keep if below key, else take key or shift right
  always_comb begin
    val_nxt = val_r;
    if (ctrl.insert && !lt) begin
      val_nxt = left_lt ? key : left_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== hw/rtl/sde_chain.sv =====
module sde_chain
  import sde_pkg::*;
#(
  parameter int LEAF_SIZE = LEAF_SIZE_DEF,
  parameter int VB        = VALUE_BITS_DEF,
  parameter int CW        = $clog2(LEAF_SIZE + 1)
) (
  input  logic                 clk,
  input  chain_ctrl_t          ctrl,
  input  logic signed [VB-1:0] key,
  input  logic [CW-1:0]        dcnt,
  output logic                 dup,
  output logic [CW-1:0]        code,
  output logic [VB-1:0]        rd_val
);

  logic signed [VB-1:0] val_w [LEAF_SIZE];
  logic                 lt_w  [LEAF_SIZE];
  logic                 eq_w  [LEAF_SIZE];
  logic [VB-1:0]        sel_w [LEAF_SIZE];

  for (genvar i = 0; i < LEAF_SIZE; i++) begin : g_cell
    logic signed [VB-1:0] lv;
    logic                 llt;
    if (i == 0) begin : g_head
      assign lv  = key;
      assign llt = 1'b1;
    end else begin : g_body
      assign lv  = val_w[i-1];
      assign llt = lt_w[i-1];
    end
    sde_cell #(.VB(VB), .CW(CW), .IDX(i)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .key     (key),
      .dcnt    (dcnt),
      .left_val(lv),
      .left_lt (llt),
      .val     (val_w[i]),
      .lt      (lt_w[i]),
      .eq      (eq_w[i]),
      .sel_val (sel_w[i])
    );
  end

  // entries are distinct, so at most one eq bit is set
  always_comb begin
    dup    = 1'b0;
    code   = '0;
    rd_val = '0;
    for (int i = 0; i < LEAF_SIZE; i++) begin
      dup    = dup | eq_w[i];
      code   = code | (eq_w[i] ? CW'(i) : '0);
      rd_val = rd_val | sel_w[i];
    end
  end

endmodule
